/* rtl/core/ctpf_pkg.sv */
package ctpf_pkg;

  localparam int FrameBytes = 18;
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int CountW     = 14;
  localparam int ApidW      = 11;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = ApidW;
  localparam int QueueDepth = 2;

  localparam logic [7:0]  SyncFirst  = 8'hAA;
  localparam logic [7:0]  SyncSecond = 8'h55;
  localparam logic [15:0] PacketLen  = 16'd14;
  localparam logic [15:0] DataLenFld = 16'd7;

  typedef logic [IdxW-1:0] byte_idx_t;

  localparam byte_idx_t LastIdx = byte_idx_t'(FrameBytes - 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_APID      = 3'd0,
    REG_VERSION   = 3'd1,
    REG_TYPE      = 3'd2,
    REG_SEC_HDR   = 3'd3,
    REG_SEQ_FLAGS = 3'd4
  } cfg_reg_t;

  // per-frame fields that vary; fixed bytes come from the constants above or are zero
  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] seq;
    logic [15:0] temp;
    logic [15:0] hum;
  } frame_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] frame_byte_sel(frame_desc_t d, byte_idx_t idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = SyncFirst;
      5'd1:    b = SyncSecond;
      5'd2:    b = PacketLen[7:0];
      5'd3:    b = PacketLen[15:8];
      5'd4:    b = d.pid[15:8];
      5'd5:    b = d.pid[7:0];
      5'd6:    b = d.seq[15:8];
      5'd7:    b = d.seq[7:0];
      5'd8:    b = DataLenFld[15:8];
      5'd9:    b = DataLenFld[7:0];
      5'd14:   b = d.temp[15:8];
      5'd15:   b = d.temp[7:0];
      5'd16:   b = d.hum[15:8];
      5'd17:   b = d.hum[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/ccsds_telemetry_packet_framer_core.sv */
// channel  dir  handshake               payload
// in       in   in_tvalid/in_tready     in_tdata: temperature_centi, humidity_centi
// out      out  out_tvalid/out_tready   out_tdata: frame_byte; out_tlast: frame_end
// cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One sample gives an 18-beat frame, one beat per cycle while out_tready is high;
// the serialiser's byte counter steps through the beats of the frame.
// A two-entry descriptor queue lets samples be taken while a frame is going out.
// Synchronous reset restores register defaults and clears the sequence count.
// Output stalls hold the current beat; input stalls only when the queue is full.
module ccsds_telemetry_packet_framer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // temperature_centi, humidity_centi
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // frame_byte
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ctpf_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ctpf_pkg::CfgDataW-1:0]   cfg_data
);
  import ctpf_pkg::*;

  q_status_t   q_status;
  frame_desc_t q_wdata, q_rdata;
  logic        q_push, q_pop;

  ctpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  ctpf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  ctpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/core/ctpf_front.sv */
module ctpf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ctpf_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ctpf_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,
  input  ctpf_pkg::q_status_t             q_status,
  output logic                            q_push,
  output ctpf_pkg::frame_desc_t           q_wdata
);
  import ctpf_pkg::*;

  logic [ApidW-1:0]  apid_r,     apid_nxt;
  logic [2:0]        version_r,  version_nxt;
  logic              type_r,     type_nxt;
  logic              sec_hdr_r,  sec_hdr_nxt;
  logic [1:0]        seq_flags_r, seq_flags_nxt;
  logic [CountW-1:0] count_r,    count_nxt;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    apid_nxt      = apid_r;
    version_nxt   = version_r;
    type_nxt      = type_r;
    sec_hdr_nxt   = sec_hdr_r;
    seq_flags_nxt = seq_flags_r;
    if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_APID:      apid_nxt      = cfg_data[ApidW-1:0];
        REG_VERSION:   version_nxt   = cfg_data[2:0];
        REG_TYPE:      type_nxt      = cfg_data[0];
        REG_SEC_HDR:   sec_hdr_nxt   = cfg_data[0];
        REG_SEQ_FLAGS: seq_flags_nxt = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = ~q_status.full;
  assign q_push    = in_tvalid & in_tready;
  assign count_nxt = q_push ? count_r + CountW'(1) : count_r;

  always_comb begin
    q_wdata.pid  = {version_r, type_r, sec_hdr_r, apid_r};
    q_wdata.seq  = {seq_flags_r, count_r};
    q_wdata.temp = in_tdata[15:0];
    q_wdata.hum  = in_tdata[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apid_r      <= ApidW'(150);
      version_r   <= 3'd0;
      type_r      <= 1'b0;
      sec_hdr_r   <= 1'b1;
      seq_flags_r <= 2'd3;
      count_r     <= '0;
    end else begin
      apid_r      <= apid_nxt;
      version_r   <= version_nxt;
      type_r      <= type_nxt;
      sec_hdr_r   <= sec_hdr_nxt;
      seq_flags_r <= seq_flags_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

/* rtl/core/ctpf_queue.sv */
module ctpf_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ctpf_pkg::frame_desc_t  wdata,
  input  logic                   pop,
  output ctpf_pkg::frame_desc_t  rdata,
  output ctpf_pkg::q_status_t    status
);
  import ctpf_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  frame_desc_t       mem_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]     fill_r,   fill_nxt;
  logic              do_push, do_pop;

  assign status.full  = (fill_r == (PtrW+1)'(QueueDepth));
  assign status.empty = (fill_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

/* rtl/core/ctpf_back.sv */
module ctpf_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctpf_pkg::q_status_t    q_status,
  input  ctpf_pkg::frame_desc_t  q_rdata,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);
  import ctpf_pkg::*;

  logic        busy_r, busy_nxt;
  byte_idx_t   idx_r,  idx_nxt;
  frame_desc_t desc_r, desc_nxt;
  logic        beat, last_beat;

  assign out_tvalid = busy_r;
  assign out_tdata  = frame_byte_sel(desc_r, idx_r);
  assign out_tlast  = (idx_r == LastIdx);

  assign beat      = busy_r & out_tready;
  assign last_beat = beat & out_tlast;
  assign q_pop     = ~q_status.empty & (~busy_r | last_beat);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    desc_nxt = desc_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      desc_nxt = q_rdata;
    end else if (last_beat) begin
      busy_nxt = 1'b0;
      idx_nxt  = '0;
    end else if (beat) begin
      idx_nxt  = idx_r + byte_idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
